[design/cfq_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the circular FIFO queue.
package cfq_pkg;

  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned FIELD_W        = 32;
  localparam int unsigned CMD_W          = 2;
  localparam int unsigned STATUS_W       = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ   = 2'd0,
    CMD_DEQ   = 2'd1,
    CMD_FRONT = 2'd2,
    CMD_REAR  = 2'd3
  } cfq_cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } cfq_status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_RESP = 2'd2
  } cfq_state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic exec;
    logic resp;
  } cfq_ctrl_t;

endpackage

[design/cfq_ctrl.sv]
`timescale 1ns / 1ps
// Controller state machine: accept a request, execute it, present the result.
module cfq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  output cfq_pkg::cfq_ctrl_t ctrl_o
);
  import cfq_pkg::*;

  cfq_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    busy    = 1'b1;
    case (state_q)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctrl_o.load = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        ctrl_o.exec = 1'b1;
        state_d     = S_RESP;
      end
      S_RESP: begin
        ctrl_o.resp = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

[design/cfq_datapath.sv]
`timescale 1ns / 1ps
// Datapath: slot memory, head and tail pointers, fill count and result registers.
module cfq_datapath #(
  parameter int unsigned DEPTH      = cfq_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = cfq_pkg::DATA_WIDTH_DEF,
  localparam int unsigned CntW      = $clog2(DEPTH + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cfq_pkg::cfq_ctrl_t                ctrl_i,
  input  logic [cfq_pkg::CMD_W-1:0]         cmd_i,
  input  logic signed [cfq_pkg::FIELD_W-1:0] data_in_i,
  output logic signed [cfq_pkg::FIELD_W-1:0] data_out_o,
  output logic [cfq_pkg::STATUS_W-1:0]      status_o,
  output logic [CntW-1:0]                   count_o,
  output logic                              is_empty_o,
  output logic                              is_full_o
);
  import cfq_pkg::*;

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic [DATA_WIDTH-1:0] rd_q;
  logic [PtrW-1:0]       head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  cfq_cmd_e              cmd_q;
  logic [DATA_WIDTH-1:0] wdata_q;
  cfq_status_e           st_q, st_d;
  logic                  we;
  logic [PtrW-1:0]       raddr;
  logic [PtrW-1:0]       rear;
  logic                  empty, full;

  assign empty = (cnt_q == '0);
  assign full  = (cnt_q == FullCnt);
  assign rear  = (tail_q == '0) ? LastPtr : tail_q - 1'b1;
  assign raddr = (cmd_q == CMD_REAR) ? rear : head_q;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    st_d   = ST_OK;
    we     = 1'b0;
    case (cmd_q)
      CMD_ENQ: begin
        if (full) begin
          st_d = ST_OVERFLOW;
        end else begin
          we     = 1'b1;
          tail_d = (tail_q == LastPtr) ? '0 : tail_q + 1'b1;
          cnt_d  = cnt_q + 1'b1;
        end
      end
      CMD_DEQ: begin
        if (empty) begin
          st_d = ST_UNDERFLOW;
        end else begin
          head_d = (head_q == LastPtr) ? '0 : head_q + 1'b1;
          cnt_d  = cnt_q - 1'b1;
        end
      end
      default: begin
        if (empty) begin
          st_d = ST_UNDERFLOW;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else if (ctrl_i.exec) begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  // Request and result payload; no reset needed.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q   <= cfq_cmd_e'(cmd_i);
      wdata_q <= DATA_WIDTH'($unsigned(data_in_i));
    end
    if (ctrl_i.exec) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec && we) begin
      mem_q[tail_q] <= wdata_q;
    end
    if (ctrl_i.exec) begin
      rd_q <= mem_q[raddr];
    end
  end

  always_comb begin
    if (st_q == ST_UNDERFLOW) begin
      data_out_o = FIELD_W'({DATA_WIDTH{1'b1}});
    end else if (cmd_q == CMD_ENQ) begin
      data_out_o = '0;
    end else begin
      data_out_o = FIELD_W'(rd_q);
    end
  end

  assign status_o   = st_q;
  assign count_o    = cnt_q;
  assign is_empty_o = empty;
  assign is_full_o  = full;

endmodule

[design/circular_fifo_queue_top.sv]
`timescale 1ns / 1ps
// Top level of the circular FIFO queue.
//
// A request is taken at a rising edge with start high and busy low. It carries
// cmd_i (enqueue, dequeue, peek front, peek rear) and data_in_i, which only an
// enqueue stores. Every request yields exactly one result, shown for one cycle
// with done_o high: data_out_o, status_o (ok, overflow, underflow), count_o and
// the empty and full flags, all taken after the request.
// Sequence: the accepting edge moves the controller from idle to execute, then to
// respond, where done_o is high. busy stays high from that edge until the result
// cycle ends, so no new request is taken until the last result has been shown.
// The cycle after acceptance does the single memory access (write at the tail
// or read at head or rear) and the pointer and count update.
// Enqueue on a full queue stores nothing and reports overflow with data 0;
// dequeue or peek on an empty queue returns all ones and reports underflow.
// Reset empties the queue: pointers and count go to zero, the controller to
// idle. The slot memory is not cleared; only written slots are ever read.
// The receiver cannot stall: a result must be taken in its done_o cycle.
module circular_fifo_queue_top #(
  parameter int unsigned DEPTH      = cfq_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = cfq_pkg::DATA_WIDTH_DEF,
  localparam int unsigned CntW      = $clog2(DEPTH + 1)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [cfq_pkg::CMD_W-1:0]          cmd_i,
  input  logic signed [cfq_pkg::FIELD_W-1:0] data_in_i,
  output logic                               done_o,
  output logic signed [cfq_pkg::FIELD_W-1:0] data_out_o,
  output logic [cfq_pkg::STATUS_W-1:0]       status_o,
  output logic [CntW-1:0]                    count_o,
  output logic                               is_empty_o,
  output logic                               is_full_o
);
  import cfq_pkg::*;

  cfq_ctrl_t ctrl;

  cfq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .ctrl_o (ctrl)
  );

  cfq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .cmd_i      (cmd_i),
    .data_in_i  (data_in_i),
    .data_out_o (data_out_o),
    .status_o   (status_o),
    .count_o    (count_o),
    .is_empty_o (is_empty_o),
    .is_full_o  (is_full_o)
  );

  assign done_o = ctrl.resp;

endmodule

[design/cfq_checker.sv]
`timescale 1ns / 1ps
// Port-level checker of the circular FIFO queue and its bind.
module cfq_checker #(
  parameter int unsigned DEPTH = cfq_pkg::DEPTH_DEF,
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               start,
  input logic                               busy,
  input logic                               done_o,
  input logic [cfq_pkg::STATUS_W-1:0]       status_o,
  input logic [CntW-1:0]                    count_o,
  input logic                               is_empty_o,
  input logic                               is_full_o
);
  import cfq_pkg::*;

  // Each accepted request must be followed by its result strobe on done_o.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 done_o)
    else $error("result strobe missing two cycles after request");

  a_idle_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy)
    else $error("busy still high after result");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (is_empty_o == (count_o == '0)) &&
               (is_full_o == (count_o == CntW'(DEPTH))))
    else $error("empty/full flags disagree with count");

  a_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_UNDERFLOW) |-> is_empty_o)
    else $error("underflow reported on non-empty queue");

  a_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_OVERFLOW) |-> is_full_o)
    else $error("overflow reported on non-full queue");

endmodule

bind circular_fifo_queue_top cfq_checker #(.DEPTH(DEPTH)) u_cfq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .done_o     (done_o),
  .status_o   (status_o),
  .count_o    (count_o),
  .is_empty_o (is_empty_o),
  .is_full_o  (is_full_o)
);

[verif/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the circular FIFO queue with a shadow queue predictor.
module testbench;
  import cfq_pkg::*;

  localparam int unsigned Depth = DEPTH_DEF;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  typedef struct {
    cfq_cmd_e           cmd;
    logic signed [31:0] data;
    bit                 drain_first;
  } fifo_req_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic [1:0]         status;
    logic [CntW-1:0]    count;
    logic               empty;
    logic               full;
  } fifo_resp_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      start;
  logic                      busy;
  logic [CMD_W-1:0]          cmd_i;
  logic signed [FIELD_W-1:0] data_in_i;
  logic                      done_o;
  logic signed [FIELD_W-1:0] data_out_o;
  logic [STATUS_W-1:0]       status_o;
  logic [CntW-1:0]           count_o;
  logic                      is_empty_o;
  logic                      is_full_o;

  circular_fifo_queue_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cmd_i      (cmd_i),
    .data_in_i  (data_in_i),
    .done_o     (done_o),
    .data_out_o (data_out_o),
    .status_o   (status_o),
    .count_o    (count_o),
    .is_empty_o (is_empty_o),
    .is_full_o  (is_full_o)
  );

  fifo_req_t  queued_cmds[$];
  fifo_resp_t expected_results[$];

  // Shadow copy of the queue contents and pointers.
  logic signed [31:0] shadow_slots[Depth];
  logic [3:0]         shadow_head;
  logic [3:0]         shadow_tail;
  logic [CntW-1:0]    shadow_fill;

  int unsigned fail_count;
  int unsigned burst_left;
  int unsigned gap_left;
  logic        req_taken;
  fifo_req_t   next_req;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic logic [3:0] wrap_next(logic [3:0] p);
    return (p == 4'(Depth - 1)) ? 4'd0 : p + 4'd1;
  endfunction

  function automatic fifo_resp_t predict_fifo_cmd(cfq_cmd_e cmd, logic signed [31:0] value);
    fifo_resp_t r;
    logic [3:0] last;
    r.data   = '0;
    r.status = ST_OK;
    if (cmd == CMD_ENQ) begin
      if (shadow_fill >= CntW'(Depth)) begin
        r.status = ST_OVERFLOW;
      end else begin
        shadow_slots[shadow_tail] = value;
        shadow_tail = wrap_next(shadow_tail);
        shadow_fill = shadow_fill + 1'b1;
      end
    end else if (shadow_fill == '0) begin
      r.data   = '1;
      r.status = ST_UNDERFLOW;
    end else if (cmd == CMD_DEQ) begin
      r.data      = shadow_slots[shadow_head];
      shadow_head = wrap_next(shadow_head);
      shadow_fill = shadow_fill - 1'b1;
    end else if (cmd == CMD_FRONT) begin
      r.data = shadow_slots[shadow_head];
    end else begin
      last   = (shadow_tail != 4'd0) ? shadow_tail - 4'd1 : 4'(Depth - 1);
      r.data = shadow_slots[last];
    end
    r.count = shadow_fill;
    r.empty = (shadow_fill == '0);
    r.full  = (shadow_fill == CntW'(Depth));
    return r;
  endfunction

  // Check results, then record the request taken at this edge.
  always @(posedge clk_i) begin
    fifo_resp_t got;
    fifo_resp_t want;
    if (rst_ni) begin
      if (done_o) begin
        got = '{data_out_o, status_o, count_o, is_empty_o, is_full_o};
        if (expected_results.size() == 0) begin
          if (fail_count < 10) begin
            $display("ERROR %0t: unexpected result data=%h status=%0d count=%0d",
                     $time, got.data, got.status, got.count);
          end
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (got.data !== want.data || got.status !== want.status ||
              got.count !== want.count || got.empty !== want.empty ||
              got.full !== want.full) begin
            if (fail_count < 10) begin
              $display("ERROR %0t: exp data=%h status=%0d count=%0d empty=%b full=%b",
                       $time, want.data, want.status, want.count, want.empty, want.full);
              $display("      %0t: got data=%h status=%0d count=%0d empty=%b full=%b",
                       $time, got.data, got.status, got.count, got.empty, got.full);
            end
            fail_count <= fail_count + 1;
          end
        end
      end
      req_taken <= start && !busy;
      if (start && !busy) begin
        expected_results.push_back(predict_fifo_cmd(cfq_cmd_e'(cmd_i), data_in_i));
      end
    end
  end

  // Request driver: bursts of back-to-back requests separated by random gaps.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!start || req_taken) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        start    <= 1'b0;
      end else if (queued_cmds.size() != 0 && queued_cmds[0].drain_first) begin
        // hold off until every outstanding result is back
        if (expected_results.size() == 0) void'(queued_cmds.pop_front());
        start <= 1'b0;
      end else if (queued_cmds.size() != 0) begin
        next_req  = queued_cmds.pop_front();
        cmd_i     <= next_req.cmd;
        data_in_i <= next_req.data;
        start     <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 30);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return '1;
      4:       return 32'($urandom_range(0, 255));
      default: return $urandom;
    endcase
  endfunction

  task automatic add_req(cfq_cmd_e cmd, logic signed [31:0] value);
    queued_cmds.push_back('{cmd, value, 1'b0});
  endtask

  task automatic add_drain();
    queued_cmds.push_back('{CMD_ENQ, '0, 1'b1});
  endtask

  initial begin
    int unsigned issued;
    int unsigned chunk_len;
    int unsigned mode;
    int unsigned pick;
    int unsigned enq_pct;
    int unsigned deq_pct;
    int unsigned front_pct;
    cfq_cmd_e    cmd;

    rst_ni      = 1'b0;
    start       = 1'b0;
    cmd_i       = CMD_ENQ;
    data_in_i   = '0;
    req_taken   = 1'b0;
    fail_count  = 0;
    burst_left  = 0;
    gap_left    = 0;
    shadow_head = '0;
    shadow_tail = '0;
    shadow_fill = '0;
    foreach (shadow_slots[i]) shadow_slots[i] = '0;

    // underflow on every read command, then fill to the brim
    add_req(CMD_DEQ, 32'sh1234_5678);
    add_req(CMD_FRONT, '1);
    add_req(CMD_REAR, '0);
    add_req(CMD_ENQ, 32'sh8000_0000);
    add_req(CMD_ENQ, 32'sh7fff_ffff);
    add_req(CMD_ENQ, '0);
    add_req(CMD_ENQ, '1);
    add_req(CMD_ENQ, 32'sh5555_5555);
    add_req(CMD_ENQ, 32'shaaaa_aaaa);
    for (int i = 0; i < 10; i++) add_req(CMD_ENQ, $urandom);
    // overflow, then rear with the tail wrapped to slot zero
    add_req(CMD_ENQ, 32'sh0bad_cafe);
    add_req(CMD_REAR, '0);
    add_req(CMD_FRONT, '0);
    add_req(CMD_DEQ, '0);
    add_drain();

    issued = 0;
    while (issued < 950) begin
      chunk_len = $urandom_range(10, 60);
      mode      = $urandom_range(0, 3);
      case (mode)
        0:       begin enq_pct = 75; deq_pct = 15; front_pct = 5;  end
        1:       begin enq_pct = 20; deq_pct = 65; front_pct = 8;  end
        2:       begin enq_pct = 45; deq_pct = 40; front_pct = 8;  end
        default: begin enq_pct = 30; deq_pct = 20; front_pct = 25; end
      endcase
      for (int i = 0; i < chunk_len; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < enq_pct) cmd = CMD_ENQ;
        else if (pick < enq_pct + deq_pct) cmd = CMD_DEQ;
        else if (pick < enq_pct + deq_pct + front_pct) cmd = CMD_FRONT;
        else cmd = CMD_REAR;
        add_req(cmd, pick_value());
      end
      issued += chunk_len;
      if ($urandom_range(0, 5) == 0) add_drain();
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (queued_cmds.size() != 0 || start || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (6) @(posedge clk_i);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("circular_fifo_queue_top regression: pass");
    end else begin
      $display("circular_fifo_queue_top regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("circular_fifo_queue_top regression: fail");
    $finish;
  end

endmodule

[filelist.f]
design/cfq_pkg.sv
design/cfq_ctrl.sv
design/cfq_datapath.sv
design/circular_fifo_queue_top.sv
design/cfq_checker.sv
verif/testbench.sv
